>>> rtl/tshc_pkg.sv
// Shared types and constants for the tile stream header checker.
// Used by tile_stream_header_checker_top; depends on nothing else.
package tshc_pkg;

   // Uncompressed bytes in one full tile
   localparam int unsigned TILE_BYTES   = 65536;
   // Fixed header length in bytes
   localparam int unsigned HEADER_BYTES = 8;

   // Stream byte counter width and its saturation value
   localparam int unsigned COUNT_W   = 34;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Width of the product used for the decoded size
   localparam int unsigned DECODE_W = 35;

   // Only valid tile-size index in the header size word
   localparam logic [1:0] SIZE_INDEX_OK = 2'd1;

   // Result codes, also used as the stored fault codes
   typedef enum logic [3:0] {
      STATUS_OK          = 4'd0,
      STATUS_SHORT       = 4'd1,
      STATUS_ID_MAGIC    = 4'd2,
      STATUS_SIZE_INDEX  = 4'd3,
      STATUS_COUNT_SIZE  = 4'd4,
      STATUS_TRUNCATED   = 4'd5,
      STATUS_NOT_INCR    = 4'd6,
      STATUS_EMPTY_LAST  = 4'd7,
      STATUS_PAST_END    = 4'd8
   } status_type;

endpackage

>>> rtl/tile_stream_header_checker_top.sv
// Tile stream header checker: one byte per cycle in, one result per stream out.
// A final byte passes stage 1, then its result word is registered in the output register.
// Throughput: one byte per cycle; the input stalls only while a final byte
//   waits on a result word that is itself stalled at the output register.
// Reset (synchronous, active high) clears all stream state, empties both
//   stages and sets the expected codec id to 4. Depends on tshc_pkg.
module tile_stream_header_checker_top
   import tshc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   // input byte channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_status,
   output logic [15:0]         rsp_tile_count,
   output logic [31:0]         rsp_decoded_bytes,
   output logic [COUNT_W-1:0]  rsp_stream_bytes
);

   // ---------------- registers ----------------
   logic [7:0]          codec_id_ff, codec_id_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff, s1_byte_in;
   logic                s1_last_ff, s1_last_in;

   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [7:0]          id_byte_ff, id_byte_in;
   logic [15:0]         tiles_seen_ff, tiles_seen_in;
   logic [31:0]         assembly_word_ff, assembly_word_in;
   logic [31:0]         size_word_ff, size_word_in;
   logic [31:0]         previous_offset_ff, previous_offset_in;
   logic [31:0]         tail_tile_bytes_ff, tail_tile_bytes_in;
   status_type          header_fault_ff, header_fault_in;
   status_type          table_fault_ff, table_fault_in;
   logic [15:0]         num_tiles_ff, num_tiles_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [15:0]         rsp_count_ff, rsp_count_in;
   logic [31:0]         rsp_decoded_ff, rsp_decoded_in;
   logic [COUNT_W-1:0]  rsp_used_ff, rsp_used_in;

   // ---------------- handshake ----------------
   logic                req_take;
   logic                advance;
   logic                process;
   logic                finish;

   // A final byte may only leave stage 1 when the output register can take it
   assign advance   = !(s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign process   = s1_valid_ff && advance;
   assign finish    = process && s1_last_ff;

   // Load stage 1 with each accepted byte; empty it when its byte moves on with none behind
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_data_byte;
         s1_last_in  = req_last;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Take configuration writes
   assign codec_id_in = csr_wr_en ? csr_wr_data : codec_id_ff;

   // ---------------- stream state update ----------------
   logic [COUNT_W-1:0]  pos;
   logic [31:0]         word_new;
   logic [17:0]         tail_size_new;
   logic                table_slot;

   assign pos           = byte_count_ff;
   assign word_new      = {s1_byte_ff, assembly_word_ff[31:8]};
   assign tail_size_new = word_new[19:2];
   assign table_slot    = (pos >= COUNT_W'(HEADER_BYTES)) && (header_fault_ff == STATUS_OK)
                          && (tiles_seen_ff < num_tiles_ff) && (pos[1:0] == 2'd3);

   always_comb begin
      byte_count_in      = byte_count_ff;
      id_byte_in         = id_byte_ff;
      tiles_seen_in      = tiles_seen_ff;
      assembly_word_in   = assembly_word_ff;
      size_word_in       = size_word_ff;
      previous_offset_in = previous_offset_ff;
      tail_tile_bytes_in = tail_tile_bytes_ff;
      header_fault_in    = header_fault_ff;
      table_fault_in     = table_fault_ff;
      num_tiles_in       = num_tiles_ff;
      if (process) begin
         assembly_word_in = word_new;
         if (pos == COUNT_W'(0)) begin
            id_byte_in = s1_byte_ff;
         end else if (pos == COUNT_W'(1)) begin
            // magic is the inverted id; id compared with the current register
            if ((s1_byte_ff != ~id_byte_ff) || (id_byte_ff != codec_id_ff)) begin
               header_fault_in = STATUS_ID_MAGIC;
            end
         end else if (pos == COUNT_W'(3)) begin
            num_tiles_in = word_new[31:16];
         end else if (pos == COUNT_W'(HEADER_BYTES - 1)) begin
            size_word_in = word_new;
            if (header_fault_ff == STATUS_OK) begin
               if (word_new[1:0] != SIZE_INDEX_OK) begin
                  header_fault_in = STATUS_SIZE_INDEX;
               end else if ((num_tiles_ff == 16'd0)
                            || (32'(tail_size_new) >= 32'(TILE_BYTES))) begin
                  header_fault_in = STATUS_COUNT_SIZE;
               end
            end
         end else if (table_slot) begin
            // table word 0 is the last tile size, the rest are offsets
            if (tiles_seen_ff == 16'd0) begin
               tail_tile_bytes_in = word_new;
            end else begin
               if ((table_fault_ff == STATUS_OK) && (word_new <= previous_offset_ff)) begin
                  table_fault_in = STATUS_NOT_INCR;
               end
               previous_offset_in = word_new;
            end
            tiles_seen_in = tiles_seen_ff + 16'd1;
         end
         // saturate the byte counter
         if (byte_count_ff != COUNT_MAX) begin
            byte_count_in = byte_count_ff + COUNT_W'(1);
         end
      end
   end

   // ---------------- end-of-stream result ----------------
   logic [COUNT_W-1:0]   data_start;
   logic [COUNT_W-1:0]   used_total;
   logic [17:0]          tail_size_fin;
   logic [DECODE_W-1:0]  full_bytes;
   logic [DECODE_W-1:0]  decoded_raw;

   assign tail_size_fin = size_word_in[19:2];
   assign data_start    = COUNT_W'(HEADER_BYTES) + COUNT_W'({num_tiles_in, 2'b00});
   assign used_total    = data_start + COUNT_W'(previous_offset_in)
                          + COUNT_W'(tail_tile_bytes_in);
   assign full_bytes    = DECODE_W'(num_tiles_in) * DECODE_W'(TILE_BYTES);
   assign decoded_raw   = (tail_size_fin != 18'd0)
                          ? (full_bytes - DECODE_W'(TILE_BYTES) + DECODE_W'(tail_size_fin))
                          : full_bytes;

   // Pick the first failing check; zero the payload on any error
   always_comb begin
      rsp_status_in  = STATUS_OK;
      rsp_count_in   = 16'd0;
      rsp_decoded_in = 32'd0;
      rsp_used_in    = '0;
      if (byte_count_in < COUNT_W'(HEADER_BYTES)) begin
         rsp_status_in = STATUS_SHORT;
      end else if (header_fault_in != STATUS_OK) begin
         rsp_status_in = header_fault_in;
      end else if (byte_count_in < data_start) begin
         rsp_status_in = STATUS_TRUNCATED;
      end else if (table_fault_in != STATUS_OK) begin
         rsp_status_in = table_fault_in;
      end else if (tail_tile_bytes_in == 32'd0) begin
         rsp_status_in = STATUS_EMPTY_LAST;
      end else if (used_total > byte_count_in) begin
         rsp_status_in = STATUS_PAST_END;
      end else begin
         rsp_count_in   = num_tiles_in;
         rsp_used_in    = used_total;
         rsp_decoded_in = (decoded_raw > DECODE_W'(32'hFFFF_FFFF))
                          ? 32'hFFFF_FFFF : decoded_raw[31:0];
      end
   end

   // Hold the result word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         codec_id_ff        <= 8'd4;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         byte_count_ff      <= '0;
         id_byte_ff         <= 8'd0;
         tiles_seen_ff      <= 16'd0;
         assembly_word_ff   <= 32'd0;
         size_word_ff       <= 32'd0;
         previous_offset_ff <= 32'd0;
         tail_tile_bytes_ff <= 32'd0;
         header_fault_ff    <= STATUS_OK;
         table_fault_ff     <= STATUS_OK;
         num_tiles_ff       <= 16'd0;
      end else begin
         codec_id_ff  <= codec_id_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            // drop all stream state after the final byte
            byte_count_ff      <= '0;
            id_byte_ff         <= 8'd0;
            tiles_seen_ff      <= 16'd0;
            assembly_word_ff   <= 32'd0;
            size_word_ff       <= 32'd0;
            previous_offset_ff <= 32'd0;
            tail_tile_bytes_ff <= 32'd0;
            header_fault_ff    <= STATUS_OK;
            table_fault_ff     <= STATUS_OK;
            num_tiles_ff       <= 16'd0;
         end else begin
            byte_count_ff      <= byte_count_in;
            id_byte_ff         <= id_byte_in;
            tiles_seen_ff      <= tiles_seen_in;
            assembly_word_ff   <= assembly_word_in;
            size_word_ff       <= size_word_in;
            previous_offset_ff <= previous_offset_in;
            tail_tile_bytes_ff <= tail_tile_bytes_in;
            header_fault_ff    <= header_fault_in;
            table_fault_ff     <= table_fault_in;
            num_tiles_ff       <= num_tiles_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
      if (finish) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_decoded_ff <= rsp_decoded_in;
         rsp_used_ff    <= rsp_used_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_tile_count    = rsp_count_ff;
   assign rsp_decoded_bytes = rsp_decoded_ff;
   assign rsp_stream_bytes  = rsp_used_ff;

   // ---------------- assertions ----------------
   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("final byte processed without a result word");

   a_final_clears_stream: assert property (@(posedge clock) disable iff (reset)
      finish |=> (byte_count_ff == '0) && (tiles_seen_ff == 16'd0))
      else $error("stream state not cleared after final byte");

   a_error_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK))
      |-> (rsp_count_ff == 16'd0) && (rsp_decoded_ff == 32'd0) && (rsp_used_ff == '0))
      else $error("error result carries a nonzero payload");

   a_ok_has_tiles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_OK)) |-> (rsp_count_ff != 16'd0))
      else $error("ok result with zero tiles");

   a_table_bounded: assert property (@(posedge clock) disable iff (reset)
      tiles_seen_ff <= num_tiles_ff)
      else $error("more table words taken than tiles");

endmodule
